[rtl/core/mtf_pkg.sv]
`timescale 1ns / 1ps

package mtf_pkg;

  localparam int Depth  = 16;
  localparam int IdxW   = $clog2(Depth);
  localparam int CntW   = $clog2(Depth + 1);
  localparam int ValW   = 32;
  localparam int PosW   = 4;
  localparam int StatW  = 3;
  localparam int ModeW  = 2;

  typedef enum logic [ModeW-1:0] {
    MODE_APPEND = 2'd0,
    MODE_MOVE   = 2'd1,
    MODE_LIST   = 2'd2
  } mode_e;

  typedef enum logic [StatW-1:0] {
    ST_APPENDED = 3'd0,
    ST_FULL     = 3'd1,
    ST_MOVED    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FRONT    = 3'd4,
    ST_ENTRY    = 3'd5,
    ST_EMPTY    = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_SH_RD,
    S_SH_WR,
    S_FR_WR,
    S_LS_RD,
    S_LS_EMIT
  } seq_state_e;

  typedef struct packed {
    logic                   we;
    logic [IdxW-1:0]        waddr;
    logic signed [ValW-1:0] wdata;
    logic                   re;
    logic [IdxW-1:0]        raddr;
  } mem_req_t;

  typedef struct packed {
    status_e                status;
    logic signed [ValW-1:0] value;
    logic [PosW-1:0]        pos;
    logic                   last;
  } result_t;

endpackage

[rtl/core/mtf_mem.sv]
`timescale 1ns / 1ps

module mtf_mem (
  input  logic                                   clk_i,
  input  mtf_pkg::mem_req_t                      req_i,
  output logic signed [mtf_pkg::ValW-1:0]        rdata_o
);
  import mtf_pkg::*;

  logic signed [ValW-1:0] mem_q [Depth];
  logic signed [ValW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/mtf_seq.sv]
`timescale 1ns / 1ps

module mtf_seq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic [mtf_pkg::ModeW-1:0]        mode_i,
  input  logic signed [mtf_pkg::ValW-1:0]  item_value_i,
  output logic                             in_ready_o,
  input  logic                             slot_free_i,
  output logic                             push_o,
  output mtf_pkg::result_t                 res_o,
  output mtf_pkg::mem_req_t                mem_req_o,
  input  logic signed [mtf_pkg::ValW-1:0]  mem_rdata_i
);
  import mtf_pkg::*;

  seq_state_e             state_q, state_d;
  logic signed [ValW-1:0] val_q, val_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic [IdxW-1:0]        hit_q, hit_d;
  result_t                res_q, res_d;
  logic                   accept;
  logic                   match;
  logic                   at_end;
  logic                   full;

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign match  = (mem_rdata_i == val_q);
  assign at_end = ((CntW'(idx_q) + CntW'(1)) == count_q);
  assign full   = (count_q == CntW'(Depth));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (mode_i)
            MODE_APPEND: state_d = S_LS_EMIT;
            MODE_MOVE:   state_d = (count_q == '0) ? S_LS_EMIT : S_RD;
            MODE_LIST:   state_d = (count_q == '0) ? S_LS_EMIT : S_LS_RD;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_RD:    state_d = S_CMP;
      S_CMP: begin
        if (match) begin
          state_d = (idx_q == '0) ? S_LS_EMIT : S_SH_RD;
        end else if (at_end) begin
          state_d = S_LS_EMIT;
        end else begin
          state_d = S_RD;
        end
      end
      S_SH_RD: state_d = S_SH_WR;
      S_SH_WR: state_d = (idx_q == IdxW'(1)) ? S_FR_WR : S_SH_RD;
      S_FR_WR: state_d = S_LS_EMIT;
      S_LS_RD: state_d = S_LS_EMIT;
      S_LS_EMIT: begin
        if (slot_free_i) begin
          if (res_q.status == ST_ENTRY && !at_end) begin
            state_d = S_LS_RD;
          end else if (res_q.status == ST_ENTRY || res_q.status != ST_ENTRY) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    val_d     = val_q;
    count_d   = count_q;
    idx_d     = idx_q;
    hit_d     = hit_q;
    res_d     = res_q;
    in_ready_o = (state_q == S_IDLE);
    push_o    = 1'b0;
    mem_req_o = '{we: 1'b0, waddr: '0, wdata: item_value_i, re: 1'b0, raddr: idx_q};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          val_d = item_value_i;
          idx_d = '0;
          case (mode_i)
            MODE_APPEND: begin
              if (full) begin
                res_d = '{status: ST_FULL, value: item_value_i, pos: '0, last: 1'b1};
              end else begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = count_q[IdxW-1:0];
                count_d         = count_q + CntW'(1);
                res_d = '{status: ST_APPENDED, value: item_value_i,
                          pos: PosW'(count_q), last: 1'b1};
              end
            end
            MODE_MOVE: begin
              res_d = '{status: ST_NOTFOUND, value: item_value_i, pos: '0, last: 1'b1};
            end
            MODE_LIST: begin
              res_d = '{status: ST_EMPTY, value: '0, pos: '0, last: 1'b1};
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        mem_req_o.re = 1'b1;
      end
      S_CMP: begin
        if (match) begin
          hit_d = idx_q;
          if (idx_q == '0) begin
            res_d = '{status: ST_FRONT, value: val_q, pos: '0, last: 1'b1};
          end
        end else if (at_end) begin
          res_d = '{status: ST_NOTFOUND, value: val_q, pos: '0, last: 1'b1};
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      S_SH_RD: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = idx_q - IdxW'(1);
      end
      S_SH_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = idx_q;
        mem_req_o.wdata = mem_rdata_i;
        idx_d           = idx_q - IdxW'(1);
      end
      S_FR_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = '0;
        mem_req_o.wdata = val_q;
        res_d = '{status: ST_MOVED, value: val_q, pos: PosW'(hit_q), last: 1'b1};
      end
      S_LS_RD: begin
        mem_req_o.re = 1'b1;
        res_d = '{status: ST_ENTRY, value: '0, pos: PosW'(idx_q), last: at_end};
      end
      S_LS_EMIT: begin
        push_o = slot_free_i;
        if (res_q.status == ST_ENTRY) begin
          res_d.value = mem_rdata_i;
          if (slot_free_i) begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o = res_q;
    if (res_q.status == ST_ENTRY) begin
      res_o.value = mem_rdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    hit_q <= hit_d;
    res_q <= res_d;
  end

endmodule

[rtl/core/move_to_front_list_top.sv]
`timescale 1ns / 1ps
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid_i/in_ready_o | mode_i, item_value_i
// out     | output    | out_valid_o/out_ready_i | status_o, out_value_o, position_o, last_o
//
// Unused mode: item dropped with no result.
// Move: searches from the front, shifts each entry ahead of the hit back a place, then writes the front.
// List: emits each entry in turn, read through the single read port of the store; empty gives one result.
// in_ready_o is high only while the sequencer is idle; results sit in an output
// register, so a new item is taken while the last result still waits.
// Reset clears the entry count; the store itself needs no clearing pass.
// A stalled output holds the sequencer in its emit step.

module move_to_front_list_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [mtf_pkg::ModeW-1:0]       mode_i,
  input  logic signed [mtf_pkg::ValW-1:0] item_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [mtf_pkg::StatW-1:0]       status_o,
  output logic signed [mtf_pkg::ValW-1:0] out_value_o,
  output logic [mtf_pkg::PosW-1:0]        position_o,
  output logic                            last_o
);
  import mtf_pkg::*;

  mem_req_t               mem_req;
  logic signed [ValW-1:0] mem_rdata;
  result_t                res;
  logic                   push;
  logic                   slot_free;
  logic                   out_valid_q, out_valid_d;
  result_t                out_q;

  mtf_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  mtf_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .mode_i       (mode_i),
    .item_value_i (item_value_i),
    .in_ready_o   (in_ready_o),
    .slot_free_i  (slot_free),
    .push_o       (push),
    .res_o        (res),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata)
  );

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign out_value_o = out_q.value;
  assign position_o  = out_q.pos;
  assign last_o      = out_q.last;

endmodule

[rtl/core/mtf_checker.sv]
`timescale 1ns / 1ps

module mtf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [mtf_pkg::StatW-1:0]       status_o,
  input logic signed [mtf_pkg::ValW-1:0] out_value_o,
  input logic [mtf_pkg::PosW-1:0]        position_o,
  input logic                            last_o
);
  import mtf_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(out_value_o) && $stable(position_o) && $stable(last_o))
    else $error("output item changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 3'd7)
    else $error("undefined status code");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_ENTRY |-> last_o)
    else $error("single result without last");

  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL || status_o == ST_NOTFOUND
      || status_o == ST_FRONT || status_o == ST_EMPTY) |-> position_o == '0)
    else $error("position not zero");

  a_moved_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_MOVED |-> position_o != '0)
    else $error("moved entry reported at front");

endmodule

bind move_to_front_list_top mtf_checker u_checker (.*);
